// File: rtl/bcs_pkg.sv
// Shared types, widths and codes for the ball capture sequencer.
`timescale 1ns / 1ps

package bcs_pkg;

    localparam int CNT_W      = 16;
    localparam int LIMIT_W    = 16;
    localparam int SWEEP_W    = 14;
    localparam int LEVEL_W    = 15;
    localparam int TURN_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CMP_W      = 33;

    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [SWEEP_W-1:0] sweep_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [MODE_W-1:0]  mode_t;

    localparam mode_t MODE_STAY   = 2'd0;
    localparam mode_t MODE_SHOOT  = 2'd1;
    localparam mode_t MODE_SEARCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LEVEL    = 3'd4;

    localparam limit_t RST_CAPTURE_LIMIT = 16'd1000;
    localparam sweep_t RST_SWEEP_TICKS   = 14'd1000;
    localparam limit_t RST_NEAR_LIMIT    = 16'd200;
    localparam level_t RST_FORWARD_LEVEL = 15'd4915;
    localparam level_t RST_TURN_LEVEL    = 15'd6554;

    localparam count_t CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        limit_t        capture_limit;
        sweep_t        sweep_ticks;
        logic [15:0]   sweep_total;
        limit_t        near_limit;
        level_t        forward_level;
        level_t        turn_level;
    } bcs_cfg_t;

    typedef struct packed {
        count_t gate_count;
        count_t lost_count;
        count_t near_count;
        logic   far_last;
        logic   first_pending;
    } bcs_state_t;

    typedef struct packed {
        logic               drive_update;
        level_t             forward_drive;
        logic [TURN_W-1:0]  turn_drive;
        mode_t              next_mode;
    } bcs_result_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == CNT_MAX) ? v : v + count_t'(1);
    endfunction

endpackage

// File: rtl/bcs_step.sv
// Per-tick decision logic: next counter state and the drive/mode result.
`timescale 1ns / 1ps

module bcs_step (
    input  logic                command,
    input  logic                gate_seen,
    input  logic                near_echo,
    input  logic                far_echo,
    input  bcs_pkg::bcs_cfg_t   cfg,
    input  bcs_pkg::bcs_state_t st,
    output bcs_pkg::bcs_state_t st_next,
    output bcs_pkg::bcs_result_t res
);
    import bcs_pkg::*;

    count_t gate_inc;
    count_t lost_inc;
    count_t near_inc;

    assign gate_inc = sat_inc(st.gate_count);
    assign lost_inc = sat_inc(st.lost_count);
    assign near_inc = sat_inc(st.near_count);

    always_comb begin
        st_next = st;
        res     = '0;
        if (command) begin
            st_next.lost_count    = '0;
            st_next.first_pending = 1'b1;
        end else if (gate_seen) begin
            if (st.first_pending) begin
                st_next.first_pending = 1'b0;
                st_next.gate_count    = '0;
            end else begin
                st_next.lost_count = '0;
                st_next.near_count = '0;
                if (CMP_W'(gate_inc) > CMP_W'(cfg.capture_limit)) begin
                    res.next_mode      = MODE_SHOOT;
                    res.drive_update   = 1'b1;
                    st_next.gate_count = '0;
                end else begin
                    st_next.gate_count = gate_inc;
                end
            end
        end else if (near_echo || far_echo) begin
            res.drive_update   = 1'b1;
            res.forward_drive  = cfg.forward_level;
            st_next.lost_count = '0;
            st_next.near_count = '0;
            st_next.far_last   = !near_echo;
        end else if (st.far_last) begin
            st_next.near_count = '0;
            st_next.lost_count = lost_inc;
            res.drive_update   = 1'b1;
            // sweep left first, then right once past one leg
            if (CMP_W'(lost_inc) > CMP_W'(cfg.sweep_ticks)) begin
                res.turn_drive = {1'b0, cfg.turn_level};
            end else begin
                res.turn_drive = TURN_W'(0) - {1'b0, cfg.turn_level};
            end
            if (CMP_W'(lost_inc) > CMP_W'(cfg.sweep_total)) begin
                st_next.lost_count = '0;
                res.next_mode      = MODE_SEARCH;
            end
        end else if (CMP_W'(st.near_count) < CMP_W'(cfg.near_limit)) begin
            res.drive_update   = 1'b1;
            res.forward_drive  = cfg.forward_level;
            st_next.lost_count = '0;
            st_next.near_count = near_inc;
            st_next.far_last   = 1'b0;
        end else begin
            st_next.near_count = '0;
            st_next.far_last   = 1'b1;
        end
    end

endmodule

// File: rtl/ball_capture_sequencer.sv
// Top level: config registers, sequencer state and registered result beat.
// Each result beat appears on m_* in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while m_ready takes each result; the result register
// frees as it is taken, so s_ready is high whenever the output is empty or being taken.
// Reset (aresetn low, synchronous): counters cleared, far_last set,
// config registers back to defaults, no result pending.
`timescale 1ns / 1ps

module ball_capture_sequencer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bcs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic                               s_gate_seen,
    input  logic                               s_near_echo,
    input  logic                               s_far_echo,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_drive_update,
    output logic [bcs_pkg::LEVEL_W-1:0]        m_forward_drive,
    output logic signed [bcs_pkg::TURN_W-1:0]  m_turn_drive,
    output logic [bcs_pkg::MODE_W-1:0]         m_next_mode
);
    import bcs_pkg::*;

    bcs_cfg_t    cfg_reg;
    bcs_state_t  state_reg;
    bcs_state_t  state_next;
    bcs_result_t res_next;
    bcs_result_t res_reg;
    logic        valid_reg;
    logic        accept;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.capture_limit <= RST_CAPTURE_LIMIT;
            cfg_reg.sweep_ticks   <= RST_SWEEP_TICKS;
            cfg_reg.sweep_total   <= {1'b0, RST_SWEEP_TICKS, 1'b0} + {2'b00, RST_SWEEP_TICKS};
            cfg_reg.near_limit    <= RST_NEAR_LIMIT;
            cfg_reg.forward_level <= RST_FORWARD_LEVEL;
            cfg_reg.turn_level    <= RST_TURN_LEVEL;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CAPTURE_LIMIT: cfg_reg.capture_limit <= cfg_wdata[LIMIT_W-1:0];
                REG_SWEEP_TICKS: begin
                    cfg_reg.sweep_ticks <= cfg_wdata[SWEEP_W-1:0];
                    // three legs per sweep, kept as a register
                    cfg_reg.sweep_total <= {1'b0, cfg_wdata[SWEEP_W-1:0], 1'b0}
                                         + {2'b00, cfg_wdata[SWEEP_W-1:0]};
                end
                REG_NEAR_LIMIT:    cfg_reg.near_limit    <= cfg_wdata[LIMIT_W-1:0];
                REG_FORWARD_LEVEL: cfg_reg.forward_level <= cfg_wdata[LEVEL_W-1:0];
                REG_TURN_LEVEL:    cfg_reg.turn_level    <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    bcs_step u_step (
        .command   (s_command),
        .gate_seen (s_gate_seen),
        .near_echo (s_near_echo),
        .far_echo  (s_far_echo),
        .cfg       (cfg_reg),
        .st        (state_reg),
        .st_next   (state_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.gate_count    <= '0;
            state_reg.lost_count    <= '0;
            state_reg.near_count    <= '0;
            state_reg.far_last      <= 1'b1;
            state_reg.first_pending <= 1'b0;
            valid_reg               <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_drive_update  = res_reg.drive_update;
    assign m_forward_drive = res_reg.forward_drive;
    assign m_turn_drive    = res_reg.turn_drive;
    assign m_next_mode     = res_reg.next_mode;

endmodule

// File: rtl/bcs_checker.sv
// Port-level assertions for the ball capture sequencer, bound to the top level.
`timescale 1ns / 1ps

module bcs_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               s_command,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_drive_update,
    input logic [bcs_pkg::LEVEL_W-1:0]        m_forward_drive,
    input logic signed [bcs_pkg::TURN_W-1:0]  m_turn_drive,
    input logic [bcs_pkg::MODE_W-1:0]         m_next_mode
);
    import bcs_pkg::*;

    // held result beat must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_update)
            && $stable(m_forward_drive) && $stable(m_turn_drive) && $stable(m_next_mode))
        else $error("result beat changed while stalled");

    a_no_drive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_drive_update |-> m_forward_drive == '0 && m_turn_drive == '0)
        else $error("drive levels nonzero without drive update");

    a_enter_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command |=> m_valid && !m_drive_update
            && m_next_mode == MODE_STAY)
        else $error("enter command gave wrong result");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

endmodule

bind ball_capture_sequencer bcs_checker u_bcs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_command       (s_command),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_drive_update  (m_drive_update),
    .m_forward_drive (m_forward_drive),
    .m_turn_drive    (m_turn_drive),
    .m_next_mode     (m_next_mode)
);

// File: dv/tb_ball_capture_sequencer.sv
// Self-checking testbench for ball_capture_sequencer: directed ticks, then random phases.
`timescale 1ns / 1ps

module tb_ball_capture_sequencer;
    import bcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int PHASE_BEATS = 400;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef logic [TURN_W-1:0] turn_t;

    class capture_mirror;
        limit_t capture_limit;
        sweep_t sweep_ticks;
        limit_t near_limit;
        level_t forward_level;
        level_t turn_level;
        count_t gate_cnt;
        count_t lost_cnt;
        count_t near_cnt;
        bit     far_last;
        bit     first_pending;
        bcs_result_t due_results[$];
        int errors;
        int ticks;
        int shoots;
        int searches;
        int forwards;
        int turns;

        function new();
            capture_limit = RST_CAPTURE_LIMIT;
            sweep_ticks   = RST_SWEEP_TICKS;
            near_limit    = RST_NEAR_LIMIT;
            forward_level = RST_FORWARD_LEVEL;
            turn_level    = RST_TURN_LEVEL;
            gate_cnt      = '0;
            lost_cnt      = '0;
            near_cnt      = '0;
            far_last      = 1'b1;
            first_pending = 1'b0;
        endfunction

        function count_t count_up(count_t v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CAPTURE_LIMIT: capture_limit = limit_t'(data);
                REG_SWEEP_TICKS:   sweep_ticks   = sweep_t'(data);
                REG_NEAR_LIMIT:    near_limit    = limit_t'(data);
                REG_FORWARD_LEVEL: forward_level = level_t'(data);
                REG_TURN_LEVEL:    turn_level    = level_t'(data);
                default: ;
            endcase
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
        endfunction

        // Accepted input beat: advance the mirrored state and queue the expected result.
        function void take_tick(bit cmd, bit gate, bit nr, bit fr);
            bcs_result_t r;
            r = '0;
            r.next_mode = MODE_STAY;
            ticks++;
            if (cmd) begin
                lost_cnt = '0;
                first_pending = 1'b1;
            end else if (gate) begin
                if (first_pending) begin
                    first_pending = 1'b0;
                    gate_cnt = '0;
                end else begin
                    gate_cnt = count_up(gate_cnt);
                    lost_cnt = '0;
                    near_cnt = '0;
                    if (gate_cnt > capture_limit) begin
                        r.next_mode = MODE_SHOOT;
                        r.drive_update = 1'b1;
                        gate_cnt = '0;
                    end
                end
            end else if (nr || fr) begin
                r.drive_update = 1'b1;
                r.forward_drive = forward_level;
                lost_cnt = '0;
                near_cnt = '0;
                far_last = !nr;
            end else if (far_last) begin
                near_cnt = '0;
                lost_cnt = count_up(lost_cnt);
                r.drive_update = 1'b1;
                if (lost_cnt > count_t'(sweep_ticks))
                    r.turn_drive = turn_t'(turn_level);
                else
                    r.turn_drive = turn_t'(0) - turn_t'(turn_level);
                if (32'(lost_cnt) > 3 * 32'(sweep_ticks)) begin
                    lost_cnt = '0;
                    r.next_mode = MODE_SEARCH;
                end
            end else if (near_cnt < near_limit) begin
                r.drive_update = 1'b1;
                r.forward_drive = forward_level;
                lost_cnt = '0;
                near_cnt = count_up(near_cnt);
                far_last = 1'b0;
            end else begin
                near_cnt = '0;
                far_last = 1'b1;
            end
            if (r.next_mode == MODE_SHOOT) shoots++;
            if (r.next_mode == MODE_SEARCH) searches++;
            if (r.forward_drive != '0) forwards++;
            if (r.turn_drive != '0) turns++;
            due_results.push_back(r);
        endfunction

        function void match_result(logic upd, level_t fwd, turn_t trn, mode_t mode);
            bcs_result_t e;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result beat: upd=%0b fwd=%0d turn=%0d mode=%0d",
                                 upd, fwd, $signed(trn), mode));
                return;
            end
            e = due_results.pop_front();
            if (upd !== e.drive_update)
                report($sformatf("drive_update exp %0b got %0b", e.drive_update, upd));
            if (fwd !== e.forward_drive)
                report($sformatf("forward_drive exp %0d got %0d", e.forward_drive, fwd));
            if (trn !== e.turn_drive)
                report($sformatf("turn_drive exp %0d got %0d", $signed(e.turn_drive),
                                 $signed(trn)));
            if (mode !== e.next_mode)
                report($sformatf("next_mode exp %0d got %0d", e.next_mode, mode));
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_command;
    logic                    s_gate_seen;
    logic                    s_near_echo;
    logic                    s_far_echo;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_drive_update;
    logic [LEVEL_W-1:0]      m_forward_drive;
    logic signed [TURN_W-1:0] m_turn_drive;
    logic [MODE_W-1:0]       m_next_mode;

    capture_mirror mirror;
    int src_idle_pct;
    int sink_idle_pct;
    int beats_sent;
    int settings_used;
    int unsigned cycles;

    ball_capture_sequencer DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_gate_seen     (s_gate_seen),
        .s_near_echo     (s_near_echo),
        .s_far_echo      (s_far_echo),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_update  (m_drive_update),
        .m_forward_drive (m_forward_drive),
        .m_turn_drive    (m_turn_drive),
        .m_next_mode     (m_next_mode)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("tb_ball_capture_sequencer NOT OK");
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            mirror.match_result(m_drive_update, m_forward_drive, m_turn_drive, m_next_mode);
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(bit cmd, bit gate, bit nr, bit fr);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_gate_seen <= gate;
        s_near_echo <= nr;
        s_far_echo  <= fr;
        do @(posedge aclk); while (!s_ready);
        mirror.take_tick(cmd, gate, nr, fr);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (mirror.pending() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        mirror.write_reg(idx, data);
        @(negedge aclk);
    endtask

    task automatic load_settings(logic [15:0] cap, logic [15:0] swp, logic [15:0] nl,
                                 logic [15:0] fwd, logic [15:0] trn);
        drain();
        write_reg(REG_CAPTURE_LIMIT, cap);
        write_reg(REG_SWEEP_TICKS, swp);
        write_reg(REG_NEAR_LIMIT, nl);
        write_reg(REG_FORWARD_LEVEL, fwd);
        write_reg(REG_TURN_LEVEL, trn);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    // One stretch of plausible sensor activity with random content.
    task automatic run_episode();
        int kind;
        int len;
        bit nr;
        kind = $urandom_range(9);
        if (kind < 3) begin
            send_beat(1'b1, 1'($urandom), 1'($urandom), 1'($urandom));
            repeat ($urandom_range(2)) send_beat(1'b0, 1'b0, 1'($urandom), 1'($urandom));
            len = $urandom_range(int'(mirror.capture_limit) + 3, 1);
            repeat (len) send_beat(1'b0, $urandom_range(15) != 0, 1'($urandom), 1'($urandom));
        end else if (kind < 5) begin
            len = $urandom_range(3 * int'(mirror.sweep_ticks) + 3, 1);
            repeat (len) send_beat(1'b0, 1'b0, 1'b0, 1'b0);
        end else if (kind < 8) begin
            repeat ($urandom_range(3, 1)) begin
                nr = 1'($urandom);
                send_beat(1'b0, 1'b0, nr, !nr || 1'($urandom));
            end
            len = $urandom_range(int'(mirror.near_limit) + 3, 1);
            repeat (len) send_beat(1'b0, 1'b0, 1'b0, 1'b0);
        end else begin
            repeat ($urandom_range(6, 1))
                send_beat($urandom_range(9) == 0, 1'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    task automatic random_phase(int src_pct, int sink_pct);
        int stop_at;
        bit paused;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at = beats_sent + PHASE_BEATS;
        paused = 1'b0;
        while (beats_sent < stop_at) begin
            if (!paused && beats_sent >= stop_at - PHASE_BEATS / 2) begin
                drain();
                paused = 1'b1;
            end
            run_episode();
        end
    endtask

    initial begin
        mirror = new();
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_command = 1'b0;
        s_gate_seen = 1'b0;
        s_near_echo = 1'b0;
        s_far_echo = 1'b0;
        src_idle_pct = 0;
        sink_idle_pct = 0;
        beats_sent = 0;
        settings_used = 1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // defaults: sweep from far_last, enter, first gate tick, echoes, near coast
        send_beat(1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(1'b1, 1'b1, 1'b1, 1'b1);
        send_beat(1'b0, 1'b1, 1'b0, 1'b0);
        send_beat(1'b0, 1'b1, 1'b1, 1'b1);
        send_beat(1'b0, 1'b0, 1'b1, 1'b0);
        send_beat(1'b0, 1'b0, 1'b0, 1'b1);
        send_beat(1'b0, 1'b0, 1'b1, 1'b1);
        send_beat(1'b0, 1'b0, 1'b0, 1'b0);

        // zero limits, full levels: immediate shoot, search and close-in loss
        load_settings(16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h7FFF);
        write_reg(REG_SPARE, 16'hFFFF);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        send_beat(1'b0, 1'b1, 1'b0, 1'b0);
        send_beat(1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(1'b0, 1'b0, 1'b1, 1'b0);
        send_beat(1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(1'b1, 1'b0, 1'b0, 1'b0);
        send_beat(1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(1'b0, 1'b1, 1'b0, 1'b1);

        // top limits (sweep written with bits above its width), zero levels
        load_settings(16'd65534, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_beat(1'b0, 1'b1, 1'b1, 1'b0);
        send_beat(1'b0, 1'b0, 1'b0, 1'b1);
        send_beat(1'b0, 1'b0, 1'b0, 1'b0);
        send_beat(1'b0, 1'b0, 1'b1, 1'b0);
        send_beat(1'b0, 1'b0, 1'b0, 1'b0);

        load_settings(16'($urandom_range(6)), {2'($urandom), 14'($urandom_range(4))},
                      16'($urandom_range(5)), 16'($urandom), 16'($urandom));
        random_phase(15, 52);
        load_settings(16'($urandom_range(12, 1)), {2'($urandom), 14'($urandom_range(8, 1))},
                      16'($urandom_range(10, 1)), 16'($urandom), 16'($urandom));
        random_phase(52, 15);
        load_settings(16'($urandom_range(3)), 16'($urandom_range(2)),
                      16'($urandom_range(3)), 16'h7FFF, 16'($urandom));
        random_phase(0, 0);

        drain();
        repeat (4) @(posedge aclk);
        $display("Covered %0d beats under %0d register settings with both sides stalling.",
                 mirror.ticks, settings_used);
        $display("Results: %0d shoot, %0d search, %0d forward, %0d turn; %0d mismatches.",
                 mirror.shoots, mirror.searches, mirror.forwards, mirror.turns, mirror.errors);
        if (mirror.errors == 0)
            $display("tb_ball_capture_sequencer OK");
        else
            $display("tb_ball_capture_sequencer NOT OK");
        $finish;
    end

endmodule
